// ----- hdl/rhp_pkg.sv -----
// rtp header parser package: widths, status codes, queue descriptor and result types
// used by every module of the rtp_header_parser block but rhp_ram; no dependencies
`default_nettype none

package rhp_pkg;

    // sizing of the block
    localparam int MAX_PACKET_BYTES = 65535;
    localparam int MAX_SOURCES      = 15;

    localparam int COUNT_W     = 16;
    localparam int HDR_BYTES   = 12;
    localparam int SRC_IDX_W   = 4;
    localparam int SRC_SLOTS   = 1 << SRC_IDX_W;
    localparam int BANK_W      = 2;
    localparam int BANKS       = 1 << BANK_W;
    localparam int OUTST_W     = BANK_W + 1;
    localparam int RAM_DEPTH   = BANKS * SRC_SLOTS;
    localparam int RAM_AW      = BANK_W + SRC_IDX_W;
    localparam int WORD_W      = 32;
    localparam int OFF_W       = 19;
    localparam int QUEUE_DEPTH = 2;
    localparam int TDATA_W     = 160;

    // header constants
    localparam logic [1:0]  RTP_VERSION    = 2'b10;
    localparam logic [16:0] EXT_WORDS_NONE = 17'h1FFFF;
    localparam logic        KIND_SUMMARY   = 1'b0;
    localparam logic        KIND_SOURCE    = 1'b1;

    typedef enum logic [3:0] {
        ST_OK            = 4'd0,
        ST_NOT_RTP       = 4'd1,
        ST_CSRC_SHORT    = 4'd2,
        ST_EXT_HDR_SHORT = 4'd3,
        ST_EXT_BODY_SHORT= 4'd4,
        ST_NO_PAD        = 4'd5,
        ST_PAD_ZERO      = 4'd6,
        ST_PAD_TOO_BIG   = 4'd7,
        ST_TOO_LONG      = 4'd8
    } status_t;

    typedef enum logic {
        PH_SUMMARY = 1'b0,
        PH_SOURCES = 1'b1
    } phase_t;

    // one classified packet, waiting in the queue for the back end
    typedef struct packed {
        status_t                        status;
        logic [COUNT_W-1:0]             plen_raw;
        logic [15:0]                    offset;
        logic [7:0]                     pad_byte;
        logic                           padding;
        logic                           ext;
        logic [3:0]                     cc;
        logic [HDR_BYTES-1:0][7:0]      header;
        logic [15:0]                    ext_profile;
        logic [15:0]                    ext_length;
        logic [BANK_W-1:0]              bank;
    } desc_t;

    typedef struct packed {
        logic  push;
        desc_t desc;
    } q_push_t;

    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] addr;
        logic [WORD_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic              re;
        logic [RAM_AW-1:0] addr;
    } ram_rd_t;

    // one result word before packing
    typedef struct packed {
        logic               kind;
        status_t            status;
        logic               marker;
        logic [6:0]         pay_type;
        logic [15:0]        seq_num;
        logic [31:0]        timestamp;
        logic [WORD_W-1:0]  source_id;
        logic [15:0]        ext_profile;
        logic [16:0]        ext_words;
        logic [15:0]        payload_offset;
        logic [15:0]        pay_len;
        logic               last_result;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/rhp_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies
`default_nettype none

module rhp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rhp_front.sv -----
// front end: byte capture, csrc writes into the source memory, packet snapshot and length checks
// depends on rhp_pkg
`default_nettype none

module rhp_front import rhp_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tlast,
    output ram_wr_t         ram_wr,
    output q_push_t         q_in,
    input  wire logic       q_full,
    input  wire logic       pkt_done
);

    logic [COUNT_W-1:0]        byte_count_reg, byte_count_next;
    logic                      overflow_reg, overflow_next;
    logic [HDR_BYTES-1:0][7:0] hdr_reg, hdr_next;
    logic [23:0]               word_reg, word_next;
    logic [15:0]               ext_prof_reg, ext_prof_next;
    logic [15:0]               ext_len_reg, ext_len_next;
    logic [BANK_W-1:0]         bank_reg, bank_next;
    logic [OUTST_W-1:0]        outst_reg, outst_next;

    logic                      snap_valid_reg, snap_valid_next;
    logic [COUNT_W-1:0]        snap_len_reg;
    logic                      snap_ovf_reg;
    logic [HDR_BYTES-1:0][7:0] snap_hdr_reg;
    logic [15:0]               snap_prof_reg;
    logic [15:0]               snap_extlen_reg;
    logic [7:0]                snap_pad_reg;
    logic [BANK_W-1:0]         snap_bank_reg;

    logic                      accept, eop, push;
    logic [COUNT_W-1:0]        cap_count;
    logic                      cap_ovf;
    logic [HDR_BYTES-1:0][7:0] cap_hdr;
    logic [15:0]               cap_prof, cap_len;
    logic [3:0]                cc;
    logic [6:0]                hoff, ext_lim, rel_csrc;
    logic                      in_hdr, in_csrc, in_ext;

    assign accept = s_tvalid && s_tready;
    assign eop    = accept && s_tlast;
    assign push   = snap_valid_reg && !q_full;

    // a byte is taken only with a free source bank and room in the snapshot
    assign s_tready = (outst_reg != OUTST_W'(BANKS)) && (!snap_valid_reg || push);

    // where the current byte falls in the header
    assign cc       = hdr_reg[0][3:0];
    assign hoff     = 7'(HDR_BYTES) + {1'b0, cc, 2'b00};
    assign ext_lim  = hoff + 7'd4;
    assign rel_csrc = byte_count_reg[6:0] - 7'(HDR_BYTES);
    assign in_hdr   = byte_count_reg < COUNT_W'(HDR_BYTES);
    assign in_csrc  = !in_hdr && (byte_count_reg < {9'b0, hoff});
    assign in_ext   = !in_hdr && !in_csrc && hdr_reg[0][4] && (byte_count_reg < {9'b0, ext_lim});

    // byte capture
    always_comb begin
        cap_count = byte_count_reg;
        cap_ovf   = overflow_reg;
        cap_hdr   = hdr_reg;
        cap_prof  = ext_prof_reg;
        cap_len   = ext_len_reg;
        word_next = word_reg;
        ram_wr    = '0;
        if (accept) begin
            if (byte_count_reg >= COUNT_W'(MAX_PACKET_BYTES)) begin
                cap_ovf = 1'b1;
            end else begin
                cap_count = byte_count_reg + 1'b1;
                if (in_hdr) begin
                    cap_hdr[byte_count_reg[3:0]] = s_tdata;
                end else if (in_csrc) begin
                    word_next = {word_reg[15:0], s_tdata};
                    if ((rel_csrc[1:0] == 2'b11) &&
                        (rel_csrc[5:2] < SRC_IDX_W'(MAX_SOURCES))) begin
                        ram_wr.we   = 1'b1;
                        ram_wr.addr = {bank_reg, rel_csrc[5:2]};
                        ram_wr.data = {word_reg, s_tdata};
                    end
                end else if (in_ext) begin
                    if (!byte_count_reg[1]) begin
                        cap_prof = {ext_prof_reg[7:0], s_tdata};
                    end else begin
                        cap_len = {ext_len_reg[7:0], s_tdata};
                    end
                end
            end
        end
    end

    // packet state clears after the last byte
    always_comb begin
        byte_count_next = eop ? '0 : cap_count;
        overflow_next   = eop ? 1'b0 : cap_ovf;
        hdr_next        = eop ? '0 : cap_hdr;
        ext_prof_next   = eop ? '0 : cap_prof;
        ext_len_next    = eop ? '0 : cap_len;
        bank_next       = eop ? bank_reg + 1'b1 : bank_reg;
        outst_next      = outst_reg + OUTST_W'(eop) - OUTST_W'(pkt_done);
        snap_valid_next = eop ? 1'b1 : (push ? 1'b0 : snap_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            overflow_reg   <= 1'b0;
            hdr_reg        <= '0;
            ext_prof_reg   <= '0;
            ext_len_reg    <= '0;
            bank_reg       <= '0;
            outst_reg      <= '0;
            snap_valid_reg <= 1'b0;
        end else begin
            byte_count_reg <= byte_count_next;
            overflow_reg   <= overflow_next;
            hdr_reg        <= hdr_next;
            ext_prof_reg   <= ext_prof_next;
            ext_len_reg    <= ext_len_next;
            bank_reg       <= bank_next;
            outst_reg      <= outst_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    // snapshot of a finished packet and the csrc byte shifter
    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        if (eop) begin
            snap_len_reg    <= cap_count;
            snap_ovf_reg    <= cap_ovf;
            snap_hdr_reg    <= cap_hdr;
            snap_prof_reg   <= cap_prof;
            snap_extlen_reg <= cap_len;
            snap_pad_reg    <= s_tdata;
            snap_bank_reg   <= bank_reg;
        end
    end

    // length checks on the snapshot
    logic [7:0]       h0;
    logic [6:0]       off0;
    logic [OFF_W-1:0] hdr_end, body_end, off_sel, len_w;
    status_t          early;

    assign h0       = snap_hdr_reg[0];
    assign off0     = 7'(HDR_BYTES) + {1'b0, h0[3:0], 2'b00};
    assign hdr_end  = {12'b0, off0} + OFF_W'(4);
    assign body_end = hdr_end + {1'b0, snap_extlen_reg, 2'b00};
    assign off_sel  = h0[4] ? body_end : {12'b0, off0};
    assign len_w    = {3'b0, snap_len_reg};

    always_comb begin
        if (snap_ovf_reg) begin
            early = ST_TOO_LONG;
        end else if ((snap_len_reg < COUNT_W'(HDR_BYTES)) || (h0[7:6] != RTP_VERSION)) begin
            early = ST_NOT_RTP;
        end else if (len_w < {12'b0, off0}) begin
            early = ST_CSRC_SHORT;
        end else if (h0[4] && (len_w < hdr_end)) begin
            early = ST_EXT_HDR_SHORT;
        end else if (h0[4] && (len_w < body_end)) begin
            early = ST_EXT_BODY_SHORT;
        end else begin
            early = ST_OK;
        end
    end

    // descriptor into the queue
    always_comb begin
        q_in.push             = push;
        q_in.desc.status      = early;
        q_in.desc.plen_raw    = snap_len_reg - off_sel[15:0];
        q_in.desc.offset      = off_sel[15:0];
        q_in.desc.pad_byte    = snap_pad_reg;
        q_in.desc.padding     = h0[5];
        q_in.desc.ext         = h0[4];
        q_in.desc.cc          = h0[3:0];
        q_in.desc.header      = snap_hdr_reg;
        q_in.desc.ext_profile = snap_prof_reg;
        q_in.desc.ext_length  = snap_extlen_reg;
        q_in.desc.bank        = snap_bank_reg;
    end

endmodule

`default_nettype wire

// ----- hdl/rhp_queue.sv -----
// short descriptor queue between the front end and the back end
// depends on rhp_pkg
`default_nettype none

module rhp_queue import rhp_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  q_push_t   q_in,
    output logic      q_full,
    output logic      head_valid,
    output desc_t     head,
    input  wire logic pop
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    desc_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;

    assign q_full     = count_reg == (PTR_W + 1)'(QUEUE_DEPTH);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (q_in.push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + (PTR_W + 1)'(q_in.push) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (q_in.push) begin
            entry_reg[wr_ptr_reg] <= q_in.desc;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/rhp_back.sv -----
// back end: padding checks, summary word, csrc words read from the source memory, output stage
// depends on rhp_pkg
`default_nettype none

module rhp_back import rhp_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               head_valid,
    input  desc_t                   head,
    output logic                    pop,
    output ram_rd_t                 ram_rd,
    input  wire logic [WORD_W-1:0]  ram_data,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,
    output logic                    m_tuser,
    output logic                    m_tlast
);

    phase_t                 phase_reg, phase_next;
    logic [SRC_IDX_W-1:0]   idx_reg, idx_next;
    logic [SRC_IDX_W-1:0]   nsrc_reg, nsrc_next;
    logic                   p1_valid_reg, p1_valid_next;
    result_t                p1_res_reg;
    logic                   p1_ram_reg;
    logic                   m_valid_reg, m_valid_next;
    result_t                m_res_reg;

    logic                   m_free, p1_go, issue;
    status_t                fin;
    logic [15:0]            plen;
    logic [SRC_IDX_W-1:0]   nsrc;
    logic                   src_last;
    result_t                sum_res, src_res, issue_res;

    assign m_free = !m_valid_reg || m_tready;
    assign p1_go  = p1_valid_reg && m_free;
    assign issue  = head_valid && (!p1_valid_reg || m_free);

    // padding checks finish the status
    always_comb begin
        fin  = head.status;
        plen = head.plen_raw;
        if ((head.status == ST_OK) && head.padding) begin
            if (head.plen_raw == '0) begin
                fin = ST_NO_PAD;
            end else if (head.pad_byte == 8'd0) begin
                fin = ST_PAD_ZERO;
            end else if (head.plen_raw < {8'b0, head.pad_byte}) begin
                fin = ST_PAD_TOO_BIG;
            end else begin
                plen = head.plen_raw - {8'b0, head.pad_byte};
            end
        end
    end

    always_comb begin
        if (fin != ST_OK) begin
            nsrc = '0;
        end else if (head.cc < SRC_IDX_W'(MAX_SOURCES)) begin
            nsrc = head.cc;
        end else begin
            nsrc = SRC_IDX_W'(MAX_SOURCES);
        end
    end

    assign src_last = ({1'b0, idx_reg} + 1'b1) == {1'b0, nsrc_reg};

    // summary word
    always_comb begin
        sum_res           = '0;
        sum_res.kind      = KIND_SUMMARY;
        sum_res.status    = fin;
        sum_res.ext_words = EXT_WORDS_NONE;
        if ((fin != ST_NOT_RTP) && (fin != ST_TOO_LONG)) begin
            sum_res.marker    = head.header[1][7];
            sum_res.pay_type  = head.header[1][6:0];
            sum_res.seq_num   = {head.header[2], head.header[3]};
            sum_res.timestamp = {head.header[4], head.header[5],
                                 head.header[6], head.header[7]};
            sum_res.source_id = {head.header[8], head.header[9],
                                 head.header[10], head.header[11]};
        end
        if (fin == ST_OK) begin
            if (head.ext) begin
                sum_res.ext_profile = head.ext_profile;
                sum_res.ext_words   = {1'b0, head.ext_length};
            end
            sum_res.payload_offset = head.offset;
            sum_res.pay_len        = plen;
        end
        sum_res.last_result = nsrc == '0;
    end

    // source entry word, id filled from memory on the way out
    always_comb begin
        src_res             = '0;
        src_res.kind        = KIND_SOURCE;
        src_res.status      = ST_OK;
        src_res.ext_words   = EXT_WORDS_NONE;
        src_res.last_result = src_last;
    end

    // phase next state
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_SUMMARY: begin
                if (issue && (nsrc != '0)) begin
                    phase_next = PH_SOURCES;
                end
            end
            PH_SOURCES: begin
                if (issue && src_last) begin
                    phase_next = PH_SUMMARY;
                end
            end
            default: phase_next = PH_SUMMARY;
        endcase
    end

    // phase outputs
    always_comb begin
        pop         = 1'b0;
        ram_rd.re   = 1'b0;
        ram_rd.addr = {head.bank, idx_reg};
        issue_res   = sum_res;
        idx_next    = idx_reg;
        nsrc_next   = nsrc_reg;
        unique case (phase_reg)
            PH_SUMMARY: begin
                if (issue) begin
                    pop       = nsrc == '0;
                    idx_next  = '0;
                    nsrc_next = nsrc;
                end
            end
            PH_SOURCES: begin
                issue_res = src_res;
                if (issue) begin
                    pop       = src_last;
                    ram_rd.re = 1'b1;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            default: begin
                issue_res = sum_res;
            end
        endcase
    end

    always_comb begin
        p1_valid_next = issue ? 1'b1 : (p1_go ? 1'b0 : p1_valid_reg);
        m_valid_next  = p1_go ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SUMMARY;
            idx_reg      <= '0;
            nsrc_reg     <= '0;
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            nsrc_reg     <= nsrc_next;
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // issue stage and output register
    always_ff @(posedge aclk) begin
        if (issue) begin
            p1_res_reg <= issue_res;
            p1_ram_reg <= phase_reg == PH_SOURCES;
        end
        if (p1_go) begin
            m_res_reg <= p1_res_reg;
            if (p1_ram_reg) begin
                m_res_reg.source_id <= ram_data;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_res_reg.kind;
    assign m_tlast  = m_res_reg.last_result;
    assign m_tdata  = {3'b000,
                       m_res_reg.pay_len,
                       m_res_reg.payload_offset,
                       m_res_reg.ext_words,
                       m_res_reg.ext_profile,
                       m_res_reg.source_id,
                       m_res_reg.timestamp,
                       m_res_reg.seq_num,
                       m_res_reg.pay_type,
                       m_res_reg.marker,
                       m_res_reg.status};

endmodule

`default_nettype wire

// ----- hdl/rtp_header_parser.sv -----
// rtp header parser top level: one packet byte per word in, summary and csrc words out.
// the summary word passes snapshot, queue, issue stage and output register; csrc words
// follow one per cycle while m_tready is high. input runs at one byte per cycle; bytes wait
// while a full two-entry queue holds a finished packet or all four source banks are busy.
// reset (aresetn low, synchronous) clears counters, queue and output stage; the source
// memory is not cleared. depends on rhp_pkg, rhp_ram, rhp_front, rhp_queue, rhp_back
`default_nettype none

module rtp_header_parser import rhp_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,   // data_byte[7:0]
    input  wire logic               s_tlast,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    // status[3:0] marker[4] pay_type[11:5] seq_num[27:12]
    // timestamp[59:28] source_id[91:60] ext_profile[107:92] ext_words[124:108]
    // payload_offset[140:125] pay_len[156:141], zero fill above
    output logic [TDATA_W-1:0]      m_tdata,
    output logic                    m_tuser,   // kind[0]
    output logic                    m_tlast
);

    ram_wr_t           ram_wr;
    ram_rd_t           ram_rd;
    logic [WORD_W-1:0] ram_data;
    q_push_t           q_in;
    logic              q_full;
    logic              head_valid;
    desc_t             head;
    logic              pkt_done;

    rhp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .ram_wr   (ram_wr),
        .q_in     (q_in),
        .q_full   (q_full),
        .pkt_done (pkt_done)
    );

    rhp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_src_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr.we),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (ram_rd.re),
        .rd_addr (ram_rd.addr),
        .rd_data (ram_data)
    );

    rhp_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_in       (q_in),
        .q_full     (q_full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pkt_done)
    );

    rhp_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pkt_done),
        .ram_rd     (ram_rd),
        .ram_data   (ram_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // the front end never pushes into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) q_in.push |-> !q_full)
        else $error("descriptor pushed into full queue");

    // the back end only retires a packet that is in the queue
    assert property (@(posedge aclk) disable iff (!aresetn) pkt_done |-> head_valid)
        else $error("packet retired from empty queue");

    // a failed summary ends its packet
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_SUMMARY) && (m_tdata[3:0] != ST_OK)) |-> m_tlast)
        else $error("failed summary not marked last");

    // source words only follow good packets
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == KIND_SOURCE)) |-> (m_tdata[3:0] == ST_OK))
        else $error("source word with bad status");

endmodule

`default_nettype wire
